// ----- rtl/stack_allocator_block_unit_defines.svh -----
// Assertion helpers for the asserting file.
`ifndef STACK_ALLOCATOR_BLOCK_UNIT_DEFINES_SVH
`define STACK_ALLOCATOR_BLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sab_pkg.sv -----
package sab_pkg;

    localparam int MAX_CHUNKS      = 64;
    localparam int IDX_W           = $clog2(MAX_CHUNKS);
    localparam int CNT_W           = $clog2(MAX_CHUNKS + 1);
    localparam int SIZE_W          = 17;
    localparam int MAX_BLOCK_BYTES = 65536;
    localparam int HEADER_BYTES    = 16;

    localparam logic [SIZE_W-1:0] MAX_BLOCK_V = SIZE_W'(MAX_BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] HEADER_V    = SIZE_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAX_CNT_V   = CNT_W'(MAX_CHUNKS);

    // Command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_RESIZE  = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOROOM = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_SIZE   = 3'd3;
    localparam logic [2:0] ST_BELOW  = 3'd4;
    localparam logic [2:0] ST_PLACE  = 3'd5;
    localparam logic [2:0] ST_FULL   = 3'd6;

    // Configuration register indexes
    localparam logic CFG_BLOCK_SIZE = 1'b0;
    localparam logic CFG_ALIGN_LOG2 = 1'b1;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = MAX_BLOCK_V;
    localparam logic [3:0]        ALIGN_RST      = 4'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] req_bytes;
        logic [15:0] new_bytes;
        logic [15:0] place_offset;
        logic [5:0]  depth_index;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [15:0]       chunk_offset;
        logic [SIZE_W-1:0] chunk_payload;
        logic [6:0]        object_count;
        logic [SIZE_W-1:0] free_bytes;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_busy;
    } dp_stat_t;

    // Round up to the alignment and add one header.
    function automatic logic [SIZE_W-1:0] chunk_need(input logic [15:0] bytes,
                                                     input logic [3:0] align_log2);
        logic [SIZE_W-1:0] mask;
        logic [SIZE_W-1:0] rounded;
        mask    = (SIZE_W'(1) << align_log2) - SIZE_W'(1);
        rounded = (SIZE_W'(bytes) + mask) & ~mask;
        return rounded + HEADER_V;
    endfunction

endpackage

// ----- rtl/stack_allocator_block_unit.sv -----
// LIFO bump allocator: one request word in, one result word out.
// The top record is read into a register when a request is accepted; the result register
// is written at commit, which waits while the result register holds a stalled word.
// No new request is taken until the current one commits; the record memory is read at
// accept and written back at commit.
// Reset (rst_n, async, low): empty stack, top offset 0, block_size 65536, align_log2 3,
// no result pending; the record memory is not cleared.
`include "stack_allocator_block_unit_defines.svh"

module stack_allocator_block_unit (
    input  logic          clk,
    input  logic          rst_n,
    // configuration write port
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [16:0]   cfg_data,
    // request channel
    input  logic          req_valid,
    output logic          req_stall,
    input  sab_pkg::req_t req,
    // result channel
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sab_pkg::rsp_t rsp
);

    sab_pkg::ctrl_cmd_t ctrl_cmd;
    sab_pkg::dp_stat_t  dp_stat;

    // Sequencer: take a word when idle, commit once the result slot is free.
    sab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (dp_stat),
        .cmd       (ctrl_cmd)
    );

    // Datapath: config registers, top/count registers, record memory, result register.
    sab_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (ctrl_cmd),
        .sts       (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // An accepted word keeps the block busy while it executes.
    `SAB_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
                     "accept did not mark busy")
    // Never overwrite a result word still held by a stalled consumer.
    `SAB_ASSERT_NOW(a_no_overwrite, ctrl_cmd.commit, !(rsp_valid && rsp_stall),
                    "commit over stalled result")
    // A commit always presents a result next cycle.
    `SAB_ASSERT_NEXT(a_commit_shows, ctrl_cmd.commit, rsp_valid, "commit without result")
    // Count bounded, and a refused request returns no offset.
    `SAB_ASSERT_NOW(a_count_bound, rsp_valid,
                    rsp.object_count <= 7'(sab_pkg::MAX_CHUNKS), "object count overflow")
    `SAB_ASSERT_NOW(a_fail_no_off, rsp_valid && (rsp.status != sab_pkg::ST_OK),
                    rsp.chunk_offset == 16'd0, "offset on failed request")

endmodule

// ----- rtl/sab_ctrl.sv -----
module sab_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sab_pkg::dp_stat_t   sts,
    output sab_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result slot can take the word
                if (!sts.slot_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next == S_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign req_stall = busy_reg;

endmodule

// ----- rtl/sab_dp.sv -----
module sab_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data,
    input  sab_pkg::req_t       req,
    input  sab_pkg::ctrl_cmd_t  cmd,
    output sab_pkg::dp_stat_t   sts,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sab_pkg::rsp_t       rsp
);

    localparam int SW = sab_pkg::SIZE_W;
    localparam int IW = sab_pkg::IDX_W;
    localparam int CW = sab_pkg::CNT_W;

    logic [SW-1:0] block_size_reg;
    logic [3:0]    align_reg;
    logic [SW-1:0] top_reg, top_next;
    logic [CW-1:0] count_reg, count_next;
    sab_pkg::req_t word_reg;
    logic [SW-1:0] rd_data_reg;
    logic          rsp_valid_reg;
    sab_pkg::rsp_t rsp_reg, rsp_next;

    logic [SW-1:0] size_mem [sab_pkg::MAX_CHUNKS];

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [SW-1:0] wr_data;

    logic [SW-1:0] eff_block;
    logic [SW-1:0] room;
    logic [SW-1:0] room_next;
    logic [SW-1:0] need_req;
    logic [SW-1:0] need_new;
    logic [SW-1:0] base;
    logic [IW-1:0] top_idx;

    // Read address from the incoming word and the live count
    always_comb
    begin
        if (req.cmd == sab_pkg::CMD_QUERY)
            rd_addr = count_reg[IW-1:0] - IW'(1) - req.depth_index[IW-1:0];
        else
            rd_addr = count_reg[IW-1:0] - IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg    <= req;
            rd_data_reg <= size_mem[rd_addr];
        end
        if (wr_en)
            size_mem[wr_addr] <= wr_data;
    end

    always_comb
    begin
        eff_block = (block_size_reg > sab_pkg::MAX_BLOCK_V) ? sab_pkg::MAX_BLOCK_V
                                                            : block_size_reg;
        room      = (eff_block > top_reg) ? (eff_block - top_reg) : '0;
        need_req  = sab_pkg::chunk_need(word_reg.req_bytes, align_reg);
        need_new  = sab_pkg::chunk_need(word_reg.new_bytes, align_reg);
        base      = (top_reg >= rd_data_reg) ? (top_reg - rd_data_reg) : '0;
        top_idx   = count_reg[IW-1:0] - IW'(1);

        top_next   = top_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IW-1:0];
        wr_data    = need_req;

        rsp_next.status        = sab_pkg::ST_OK;
        rsp_next.chunk_offset  = '0;
        rsp_next.chunk_payload = '0;

        case (word_reg.cmd)
            sab_pkg::CMD_ALLOC:
            begin
                if (need_req > room)
                    rsp_next.status = sab_pkg::ST_NOROOM;
                else if (count_reg >= sab_pkg::MAX_CNT_V)
                    rsp_next.status = sab_pkg::ST_FULL;
                else
                begin
                    rsp_next.chunk_offset = top_reg[15:0];
                    wr_en      = cmd.commit;
                    count_next = count_reg + CW'(1);
                    top_next   = top_reg + need_req;
                end
            end
            sab_pkg::CMD_RELEASE:
            begin
                if (count_reg == '0)
                    rsp_next.status = sab_pkg::ST_EMPTY;
                else if (rd_data_reg != need_req)
                    rsp_next.status = sab_pkg::ST_SIZE;
                else if (SW'(word_reg.place_offset) < base)
                    rsp_next.status = sab_pkg::ST_BELOW;
                else if (SW'(word_reg.place_offset) != base)
                    rsp_next.status = sab_pkg::ST_PLACE;
                else
                begin
                    top_next   = base;
                    count_next = count_reg - CW'(1);
                end
            end
            sab_pkg::CMD_RESIZE:
            begin
                if (count_reg == '0)
                    rsp_next.status = sab_pkg::ST_EMPTY;
                else if (SW'(word_reg.place_offset) < base)
                    rsp_next.status = sab_pkg::ST_BELOW;
                else if (SW'(word_reg.place_offset) != base)
                    rsp_next.status = sab_pkg::ST_PLACE;
                else if (rd_data_reg != need_req)
                    rsp_next.status = sab_pkg::ST_SIZE;
                else if ((need_new > need_req) && ((need_new - need_req) > room))
                    rsp_next.status = sab_pkg::ST_NOROOM;
                else
                begin
                    top_next = base + need_new;
                    wr_en    = cmd.commit;
                    wr_addr  = top_idx;
                    wr_data  = need_new;
                end
            end
            sab_pkg::CMD_QUERY:
            begin
                if (CW'(word_reg.depth_index) < count_reg)
                    rsp_next.chunk_payload = (rd_data_reg >= sab_pkg::HEADER_V)
                                           ? (rd_data_reg - sab_pkg::HEADER_V) : '0;
            end
            default:
            begin
                rsp_next.status = sab_pkg::ST_OK;
            end
        endcase

        room_next = (eff_block > top_next) ? (eff_block - top_next) : '0;
        rsp_next.object_count = 7'(count_next);
        rsp_next.free_bytes   = (room_next > sab_pkg::HEADER_V)
                              ? (room_next - sab_pkg::HEADER_V) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= sab_pkg::BLOCK_SIZE_RST;
            align_reg      <= sab_pkg::ALIGN_RST;
            top_reg        <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sab_pkg::CFG_BLOCK_SIZE: block_size_reg <= cfg_data;
                    sab_pkg::CFG_ALIGN_LOG2: align_reg      <= cfg_data[3:0];
                    default:                 align_reg      <= align_reg;
                endcase
            end
            if (cmd.commit)
            begin
                top_reg       <= top_next;
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign sts.slot_busy = rsp_valid_reg && rsp_stall;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp           = rsp_reg;

endmodule
